>>> design/stt_pkg.sv
// ----------------------------------------------------------------------------
// Source text tokenizer package
// Token kinds, scan modes, character codes, keyword table and the token
// and bundle types passed between the scanner, the queue and the emitter.
// ----------------------------------------------------------------------------
`default_nettype none

package stt_pkg;

  localparam int unsigned StartW = 24;
  localparam int unsigned LengthW = 16;
  localparam int unsigned LineW = 16;
  localparam int unsigned MaxTokens = 3;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueueAw = 2;
  localparam int unsigned KwCount = 10;

  typedef enum logic [4:0] {
    TkPlus         = 5'd0,
    TkMinus        = 5'd1,
    TkStar         = 5'd2,
    TkSlash        = 5'd3,
    TkEqual        = 5'd4,
    TkNotEqual     = 5'd5,
    TkLess         = 5'd6,
    TkLessEqual    = 5'd7,
    TkGreater      = 5'd8,
    TkGreaterEqual = 5'd9,
    TkNumber       = 5'd10,
    TkIdent        = 5'd11,
    TkType         = 5'd12,
    TkColon        = 5'd13,
    TkSemicolon    = 5'd14,
    TkVar          = 5'd15,
    TkFun          = 5'd16,
    TkEof          = 5'd17,
    TkBangError    = 5'd18,
    TkUnknownError = 5'd19
  } token_kind_e;

  typedef enum logic [2:0] {
    ModeIdle    = 3'd0,
    ModeNumber  = 3'd1,
    ModeIdent   = 3'd2,
    ModeBang    = 3'd3,
    ModeLess    = 3'd4,
    ModeGreater = 3'd5
  } scan_mode_e;

  localparam logic [7:0] ChNewline   = 8'h0a;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChBang      = 8'h21;
  localparam logic [7:0] ChStar      = 8'h2a;
  localparam logic [7:0] ChPlus      = 8'h2b;
  localparam logic [7:0] ChMinus     = 8'h2d;
  localparam logic [7:0] ChSlash     = 8'h2f;
  localparam logic [7:0] ChColon     = 8'h3a;
  localparam logic [7:0] ChSemicolon = 8'h3b;
  localparam logic [7:0] ChLess      = 8'h3c;
  localparam logic [7:0] ChEqual     = 8'h3d;
  localparam logic [7:0] ChGreater   = 8'h3e;

  // Keywords packed first character high, right aligned
  localparam logic [47:0] KwWord [KwCount] = '{
    48'h0000_6279_7465,  // byte
    48'h0068_776f_7264,  // hword
    48'h0000_776f_7264,  // word
    48'h0071_776f_7264,  // qword
    48'h0075_6279_7465,  // ubyte
    48'h7568_776f_7264,  // uhword
    48'h0075_776f_7264,  // uword
    48'h7571_776f_7264,  // uqword
    48'h0000_0076_6172,  // var
    48'h0000_0066_756e   // fun
  };
  localparam logic [2:0] KwLen [KwCount] = '{
    3'd4, 3'd5, 3'd4, 3'd5, 3'd5, 3'd6, 3'd5, 3'd6, 3'd3, 3'd3
  };
  localparam token_kind_e KwKind [KwCount] = '{
    TkType, TkType, TkType, TkType, TkType, TkType, TkType, TkType, TkVar, TkFun
  };
  localparam logic [2:0] KwType [KwCount] = '{
    3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7, 3'd0, 3'd0
  };

  typedef struct packed {
    token_kind_e        kind;
    logic [2:0]         type_kw;
    logic [StartW-1:0]  start;
    logic [LengthW-1:0] length;
    logic [LineW-1:0]   line;
  } token_t;

  typedef struct packed {
    logic [1:0]             count;
    token_t [MaxTokens-1:0] tokens;
  } bundle_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
  endfunction

endpackage

`default_nettype wire

>>> design/stt_scanner.sv
// ----------------------------------------------------------------------------
// Source text tokenizer scanner
// Classifies one character per request and builds the bundle of up to
// three tokens it completes; holds the pending run and position state.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_scanner
  import stt_pkg::*;
#(
  parameter int unsigned POSITION_BITS = 24,
  parameter int unsigned LENGTH_BITS = 16,
  parameter int unsigned LINE_BITS = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] char_code_i,
  input  wire logic       has_char_i,
  input  wire logic       end_of_source_i,
  output bundle_t         bundle_o
);

  localparam logic [LENGTH_BITS-1:0] RunKwMax = LENGTH_BITS'(6);
  localparam logic [LENGTH_BITS-1:0] RunOne = LENGTH_BITS'(1);

  scan_mode_e               mode_q, mode_d;
  logic [POSITION_BITS-1:0] start_q, start_d;
  logic [LENGTH_BITS-1:0]   run_q, run_d;
  logic [LINE_BITS-1:0]     line_q, line_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [47:0]              kw_q, kw_d;
  logic [1:0]               cnt;
  logic                     handled;
  token_t [MaxTokens-1:0]   toks;

  function automatic logic [StartW-1:0] fit_start(input logic [POSITION_BITS-1:0] p);
    logic [31:0] w;
    w = 32'(p);
    return w[StartW-1:0];
  endfunction

  function automatic logic [LengthW-1:0] fit_len(input logic [LENGTH_BITS-1:0] l);
    logic [31:0] w;
    w = 32'(l);
    return w[LengthW-1:0];
  endfunction

  function automatic logic [LineW-1:0] fit_line(input logic [LINE_BITS-1:0] l);
    logic [31:0] w;
    w = 32'(l);
    return w[LineW-1:0];
  endfunction

  function automatic token_t make_tok(input token_kind_e kind,
                                      input logic [POSITION_BITS-1:0] start,
                                      input logic [LengthW-1:0] len,
                                      input logic [LINE_BITS-1:0] line);
    token_t t;
    t.kind = kind;
    t.type_kw = 3'd0;
    t.start = fit_start(start);
    t.length = len;
    t.line = fit_line(line);
    return t;
  endfunction

  function automatic token_t flush_tok(input scan_mode_e mode,
                                       input logic [POSITION_BITS-1:0] start,
                                       input logic [LENGTH_BITS-1:0] run,
                                       input logic [47:0] kw,
                                       input logic [LINE_BITS-1:0] line);
    token_t t;
    t = make_tok(TkLess, start, LengthW'(1), line);
    case (mode)
      ModeNumber: begin
        t.kind = TkNumber;
        t.length = fit_len(run);
      end
      ModeIdent: begin
        t.kind = TkIdent;
        t.length = fit_len(run);
        if (run <= RunKwMax) begin
          for (int k = 0; k < KwCount; k++) begin
            if ((KwLen[k] == run[2:0]) && (KwWord[k] == kw)) begin
              t.kind = KwKind[k];
              t.type_kw = KwType[k];
            end
          end
        end
      end
      ModeBang:    t.kind = TkBangError;
      ModeGreater: t.kind = TkGreater;
      default:     t.kind = TkLess;
    endcase
    return t;
  endfunction

  always_comb begin
    mode_d = mode_q;
    start_d = start_q;
    run_d = run_q;
    line_d = line_q;
    pos_d = pos_q;
    kw_d = kw_q;
    cnt = 2'd0;
    handled = 1'b0;
    toks = '0;

    if (has_char_i) begin
      case (mode_q)
        ModeBang, ModeLess, ModeGreater: begin
          if (char_code_i == ChEqual) begin
            toks[cnt] = make_tok((mode_q == ModeBang) ? TkNotEqual :
                                 (mode_q == ModeLess) ? TkLessEqual : TkGreaterEqual,
                                 start_q, LengthW'(2), line_q);
            handled = 1'b1;
          end else begin
            toks[cnt] = flush_tok(mode_q, start_q, run_q, kw_q, line_q);
          end
          cnt = cnt + 2'd1;
          mode_d = ModeIdle;
        end
        ModeNumber, ModeIdent: begin
          if (is_digit(char_code_i) ||
              ((mode_q == ModeIdent) && is_letter(char_code_i))) begin
            if (run_q < RunKwMax) kw_d = {kw_q[39:0], char_code_i};
            if (run_q != '1) run_d = run_q + RunOne;
            handled = 1'b1;
          end else begin
            toks[cnt] = flush_tok(mode_q, start_q, run_q, kw_q, line_q);
            cnt = cnt + 2'd1;
            mode_d = ModeIdle;
          end
        end
        default: ;
      endcase

      if (!handled) begin
        case (char_code_i)
          ChSpace: ;
          ChNewline: begin
            if (line_q != '1) line_d = line_q + LINE_BITS'(1);
          end
          ChPlus, ChMinus, ChStar, ChSlash, ChEqual, ChColon, ChSemicolon: begin
            toks[cnt] = make_tok((char_code_i == ChPlus)  ? TkPlus :
                                 (char_code_i == ChMinus) ? TkMinus :
                                 (char_code_i == ChStar)  ? TkStar :
                                 (char_code_i == ChSlash) ? TkSlash :
                                 (char_code_i == ChEqual) ? TkEqual :
                                 (char_code_i == ChColon) ? TkColon : TkSemicolon,
                                 pos_q, LengthW'(1), line_q);
            cnt = cnt + 2'd1;
          end
          ChBang, ChLess, ChGreater: begin
            mode_d = (char_code_i == ChBang) ? ModeBang :
                     (char_code_i == ChLess) ? ModeLess : ModeGreater;
            start_d = pos_q;
          end
          default: begin
            if (is_digit(char_code_i)) begin
              mode_d = ModeNumber;
              start_d = pos_q;
              run_d = RunOne;
            end else if (is_letter(char_code_i)) begin
              mode_d = ModeIdent;
              start_d = pos_q;
              run_d = RunOne;
              kw_d = {40'd0, char_code_i};
            end else begin
              toks[cnt] = make_tok(TkUnknownError, pos_q, LengthW'(1), line_q);
              cnt = cnt + 2'd1;
            end
          end
        endcase
      end
      pos_d = pos_q + POSITION_BITS'(1);
    end

    if (end_of_source_i) begin
      if (mode_d != ModeIdle) begin
        toks[cnt] = flush_tok(mode_d, start_d, run_d, kw_d, line_d);
        cnt = cnt + 2'd1;
      end
      toks[cnt] = make_tok(TkEof, pos_d, LengthW'(0), line_d);
      cnt = cnt + 2'd1;
      mode_d = ModeIdle;
      start_d = '0;
      run_d = '0;
      line_d = '0;
      pos_d = '0;
      kw_d = '0;
    end
  end

  assign bundle_o.count = cnt;
  assign bundle_o.tokens = toks;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIdle;
      start_q <= '0;
      run_q <= '0;
      line_q <= '0;
      pos_q <= '0;
      kw_q <= '0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      start_q <= start_d;
      run_q <= run_d;
      line_q <= line_d;
      pos_q <= pos_d;
      kw_q <= kw_d;
    end
  end

endmodule

`default_nettype wire

>>> design/stt_queue.sv
// ----------------------------------------------------------------------------
// Source text tokenizer bundle queue
// Short register queue of token bundles between scanner and emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_queue
  import stt_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  bundle_t      push_data_i,
  output logic         full_o,
  input  wire logic    pop_i,
  output logic         empty_o,
  output bundle_t      head_o
);

  bundle_t              store_q [QueueDepth];
  logic [QueueAw-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QueueAw:0]     fill_q;

  assign full_o = (fill_q == (QueueAw + 1)'(QueueDepth));
  assign empty_o = (fill_q == '0);
  assign head_o = store_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + QueueAw'(1);
      if (pop_i) rd_ptr_q <= rd_ptr_q + QueueAw'(1);
      if (push_i && !pop_i) fill_q <= fill_q + (QueueAw + 1)'(1);
      else if (!push_i && pop_i) fill_q <= fill_q - (QueueAw + 1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) store_q[wr_ptr_q] <= push_data_i;
  end

endmodule

`default_nettype wire

>>> design/stt_emitter.sv
// ----------------------------------------------------------------------------
// Source text tokenizer emitter
// Walks the head bundle one token per cycle into the output register on ready.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_emitter
  import stt_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  bundle_t   head_i,
  input  wire logic empty_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output token_t    out_tok_o,
  output logic      out_last_o
);

  logic       valid_q;
  logic [1:0] idx_q;
  token_t     tok_q;
  logic       last_q;
  logic       load;
  logic       last;

  assign load = !empty_i && (!valid_q || out_ready_i);
  assign last = (idx_q == (head_i.count - 2'd1));
  assign pop_o = load && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q <= 2'd0;
    end else if (load) begin
      valid_q <= 1'b1;
      idx_q <= last ? 2'd0 : idx_q + 2'd1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      tok_q <= head_i.tokens[idx_q];
      last_q <= last;
    end
  end

  assign out_valid_o = valid_q;
  assign out_tok_o = tok_q;
  assign out_last_o = last_q;

endmodule

`default_nettype wire

>>> design/source_text_tokenizer_core.sv
// ----------------------------------------------------------------------------
// Source text tokenizer core
// Lexical scanner: one source character per request in, tokens out.
//
//   channel | handshake               | payload
//   in      | in_valid_i / in_ready_o | char_code_i, has_char_i, end_of_source_i
//   out     | out_valid_o/out_ready_i | token_kind_o, type_keyword_o, token_start_o,
//           |                         | token_length_o, line_number_o, last_result_o
//
// One character is taken per cycle; its tokens (up to three) reach the output
// one per cycle while out_ready_i allows. A four-entry bundle queue between
// scanner and emitter absorbs bursts; input stalls only while the queue is
// full. The first token of a request passes through the queue and then the
// output register before it is valid. Reset clears scan state and queue.
// ----------------------------------------------------------------------------
`default_nettype none

module source_text_tokenizer_core
  import stt_pkg::*;
#(
  parameter int unsigned POSITION_BITS = 24,
  parameter int unsigned LENGTH_BITS = 16,
  parameter int unsigned LINE_BITS = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [7:0]          char_code_i,
  input  wire logic                has_char_i,
  input  wire logic                end_of_source_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [4:0]               token_kind_o,
  output logic [2:0]               type_keyword_o,
  output logic [StartW-1:0]        token_start_o,
  output logic [LengthW-1:0]       token_length_o,
  output logic [LineW-1:0]         line_number_o,
  output logic                     last_result_o
);

  logic    accept;
  logic    full;
  logic    empty;
  logic    pop;
  bundle_t bundle;
  bundle_t head;
  token_t  tok;

  assign in_ready_o = !full;
  assign accept = in_valid_i && in_ready_o;

  stt_scanner #(
    .POSITION_BITS(POSITION_BITS),
    .LENGTH_BITS  (LENGTH_BITS),
    .LINE_BITS    (LINE_BITS)
  ) u_scanner (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .char_code_i    (char_code_i),
    .has_char_i     (has_char_i),
    .end_of_source_i(end_of_source_i),
    .bundle_o       (bundle)
  );

  stt_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (accept && (bundle.count != 2'd0)),
    .push_data_i(bundle),
    .full_o     (full),
    .pop_i      (pop),
    .empty_o    (empty),
    .head_o     (head)
  );

  stt_emitter u_emitter (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .empty_i    (empty),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_tok_o  (tok),
    .out_last_o (last_result_o)
  );

  assign token_kind_o = tok.kind;
  assign type_keyword_o = tok.type_kw;
  assign token_start_o = tok.start;
  assign token_length_o = tok.length;
  assign line_number_o = tok.line;

endmodule

`default_nettype wire
